FILE: hw/rtl/sha_pkg.sv
package sha_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] vars_t;
	typedef word_t [15:0] sched_t;

	localparam word_t PAD_WORD = 32'h8000_0000;
	localparam logic [2:0] FULL_BYTES = 3'd4;

	localparam vars_t INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t big_sig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t sml_sig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t sml_sig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

FILE: hw/rtl/sha_in_if.sv
interface sha_in_if;
	logic                valid;
	logic                ready;
	logic [31:0]         data_word;
	logic [2:0]          valid_bytes;
	logic                last_item;

	modport source (output valid, data_word, valid_bytes, last_item, input ready);
	modport sink (input valid, data_word, valid_bytes, last_item, output ready);
endinterface

FILE: hw/rtl/sha_out_if.sv
interface sha_out_if;
	logic                valid;
	logic                ready;
	logic [31:0]         digest_word;
	logic [2:0]          word_index;
	logic                last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: hw/rtl/sha_buf_ram.sv
// 16 x 32 block buffer, one write and one registered read port
module sha_buf_ram (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [3:0]     wr_addr,
	input  sha_pkg::word_t wr_data,
	input  logic [3:0]     rd_addr,
	output sha_pkg::word_t rd_data
);
	sha_pkg::word_t mem [16];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end
endmodule

FILE: hw/rtl/sha_round.sv
// one compression round plus message schedule expansion
module sha_round (
	input  sha_pkg::vars_t  vars,
	input  sha_pkg::sched_t line,
	input  sha_pkg::word_t  ram_word,
	input  logic            from_ram,
	input  logic [5:0]      rnd,
	output sha_pkg::word_t  w_cur,
	output sha_pkg::vars_t  vars_nxt
);
	sha_pkg::word_t t1, t2, ch, maj, w_exp;

	always_comb begin
		w_exp = sha_pkg::sml_sig1(line[14]) + line[9] + sha_pkg::sml_sig0(line[1]) + line[0];
		w_cur = from_ram ? ram_word : w_exp;
		ch    = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
		maj   = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
		t1    = vars[7] + sha_pkg::big_sig1(vars[4]) + ch + sha_pkg::ROUND_K[rnd] + w_cur;
		t2    = sha_pkg::big_sig0(vars[0]) + maj;
		vars_nxt[7] = vars[6];
		vars_nxt[6] = vars[5];
		vars_nxt[5] = vars[4];
		vars_nxt[4] = vars[3] + t1;
		vars_nxt[3] = vars[2];
		vars_nxt[2] = vars[1];
		vars_nxt[1] = vars[0];
		vars_nxt[0] = t1 + t2;
	end
endmodule

FILE: hw/rtl/sha256_stream_hash_core.sv
// A message word goes to the buffer when taken; every 16th word adds a compression.
// After the final request, padding writes up to 16 words, then one or two compressions,
// then the eight digest words leave one per cycle as the sink takes them.
// Input is held off while a 64-byte block is compressed by the single round unit.
// Reset: arst_n clears control, loads the initial hash and zeroes the byte count.
module sha256_stream_hash_core (
	input logic         clk,
	input logic         arst_n,
	sha_in_if.sink      in_ch,
	sha_out_if.source   out_ch
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,  // taking message words
		ST_PAD   = 6'b000010,  // writing pad, zero and length words
		ST_RD0   = 6'b000100,  // prime buffer read of word 0
		ST_ROUND = 6'b001000,  // 64 rounds
		ST_FIN   = 6'b010000,  // fold working vars into chain
		ST_OUT   = 6'b100000   // digest out
	} state_t;

	state_t          state_q;
	logic [3:0]      cnt_q;      // words held in the buffer
	logic [5:0]      rnd_q;
	logic [2:0]      idx_q;
	logic [60:0]     bytes_q;
	logic            pad_q, need80_q, lenhi_q, final_q;
	sha_pkg::vars_t  chain_q, vars_q, vars_nxt;
	sha_pkg::sched_t line_q;
	sha_pkg::word_t  w_cur, rd_data, wr_data, first_word;
	logic            wr_en, in_acc;
	logic [3:0]      rd_addr;
	logic [2:0]      nb;

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign in_acc             = in_ch.valid & in_ch.ready;
	assign out_ch.valid       = (state_q == ST_OUT);
	assign out_ch.digest_word = chain_q[idx_q];
	assign out_ch.word_index  = idx_q;
	assign out_ch.last_word   = (idx_q == 3'd7);

	// valid byte count saturates at four on the final word
	assign nb = (in_ch.valid_bytes > sha_pkg::FULL_BYTES) ? sha_pkg::FULL_BYTES
	                                                        : in_ch.valid_bytes;

	always_comb begin
		unique case (nb)
			3'd0:    first_word = sha_pkg::PAD_WORD;
			3'd1:    first_word = {in_ch.data_word[31:24], 24'h80_0000};
			3'd2:    first_word = {in_ch.data_word[31:16], 16'h8000};
			3'd3:    first_word = {in_ch.data_word[31:8], 8'h80};
			default: first_word = in_ch.data_word;
		endcase
	end

	// buffer write source: incoming word or padding sequence
	always_comb begin
		wr_en   = 1'b0;
		wr_data = in_ch.data_word;
		if (state_q == ST_IDLE) begin
			wr_en   = in_acc;
			wr_data = in_ch.last_item ? first_word : in_ch.data_word;
		end else if (state_q == ST_PAD) begin
			wr_en = 1'b1;
			priority if (need80_q) begin
				wr_data = sha_pkg::PAD_WORD;
			end else if (cnt_q == 4'd14) begin
				wr_data = bytes_q[60:29];
			end else if (cnt_q == 4'd15 && lenhi_q) begin
				wr_data = {bytes_q[28:0], 3'b000};
			end else begin
				wr_data = '0;
			end
		end
	end

	// read one word ahead of the round that consumes it
	assign rd_addr = (state_q == ST_RD0) ? 4'd0 : 4'(rnd_q + 6'd1);

	sha_buf_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sha_round u_round (
		.vars     (vars_q),
		.line     (line_q),
		.ram_word (rd_data),
		.from_ram (rnd_q < 6'd16),
		.rnd      (rnd_q),
		.w_cur    (w_cur),
		.vars_nxt (vars_nxt)
	);

	// working vars and schedule line need no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_RD0) begin
			vars_q <= chain_q;
		end else if (state_q == ST_ROUND) begin
			vars_q <= vars_nxt;
			for (int i = 0; i < 15; i++) begin
				line_q[i] <= line_q[i + 1];
			end
			line_q[15] <= w_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			rnd_q    <= '0;
			idx_q    <= '0;
			bytes_q  <= '0;
			pad_q    <= 1'b0;
			need80_q <= 1'b0;
			lenhi_q  <= 1'b0;
			final_q  <= 1'b0;
			chain_q  <= sha_pkg::INIT_HASH;
		end else begin
			if (wr_en) begin
				cnt_q <= cnt_q + 4'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_ch.last_item) begin
							bytes_q  <= bytes_q + 61'(nb);
							pad_q    <= 1'b1;
							need80_q <= (nb == sha_pkg::FULL_BYTES);
							lenhi_q  <= 1'b0;
						end else begin
							bytes_q <= bytes_q + 61'd4;
						end
						if (cnt_q == 4'd15) begin
							state_q <= ST_RD0;
						end else if (in_ch.last_item) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					priority if (need80_q) begin
						need80_q <= 1'b0;
					end else if (cnt_q == 4'd14) begin
						lenhi_q <= 1'b1;
					end else if (cnt_q == 4'd15 && lenhi_q) begin
						final_q <= 1'b1;
					end
					if (cnt_q == 4'd15) begin
						state_q <= ST_RD0;
					end
				end
				ST_RD0: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + vars_q[i];
					end
					priority if (final_q) begin
						state_q <= ST_OUT;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							chain_q <= sha_pkg::INIT_HASH;
							bytes_q <= '0;
							pad_q   <= 1'b0;
							final_q <= 1'b0;
							lenhi_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// no new request is taken while the digest drains
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input ready during digest output");

	// round counter rests at zero outside the rounds
	a_rnd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ROUND) |-> (rnd_q == 6'd0))
		else $error("round counter not parked");

	// chain value restarts after the last digest word
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.last_word)
		|=> (chain_q == sha_pkg::INIT_HASH && cnt_q == 4'd0))
		else $error("state not restored after digest");
endmodule

FILE: bench/sha256_digest_checker.sv
module sha256_digest_checker (
	input  logic clk,
	input  logic arst_n,
	sha_in_if   in_mon,
	sha_out_if  out_mon,
	output int  fail_count,
	output int  pending,
	output int  digests_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		sha_pkg::word_t digest_word;
		logic [2:0]     word_index;
		logic           last_word;
	} digest_beat_t;

	sha_pkg::word_t chain [8];
	sha_pkg::word_t msg_block [16];
	int unsigned    fill;
	logic [60:0]    msg_bytes;
	digest_beat_t   digest_q [$];

	function automatic sha_pkg::word_t ror(sha_pkg::word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic run_rounds();
		sha_pkg::word_t w [64];
		sha_pkg::word_t v [8];
		sha_pkg::word_t t1, t2, s0, s1;
		for (int t = 0; t < 16; t++) w[t] = msg_block[t];
		for (int t = 16; t < 64; t++) begin
			s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = s1 + w[t-7] + s0 + w[t-16];
		end
		for (int i = 0; i < 8; i++) v[i] = chain[i];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[t] + w[t];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain[i] += v[i];
	endtask

	task automatic load_word(sha_pkg::word_t w);
		msg_block[fill] = w;
		fill++;
		if (fill == 16) begin
			run_rounds();
			fill = 0;
		end
	endtask

	task automatic start_message();
		for (int i = 0; i < 8; i++) chain[i] = sha_pkg::INIT_HASH[i];
		fill = 0;
		msg_bytes = '0;
	endtask

	task automatic absorb_request(sha_pkg::word_t data, logic [2:0] nb_in, logic is_last);
		logic [2:0]     nb;
		logic [63:0]    bit_len;
		sha_pkg::word_t keep;
		digest_beat_t   b;
		if (!is_last) begin
			msg_bytes += 4;
			load_word(data);
		end else begin
			nb = (nb_in > sha_pkg::FULL_BYTES) ? sha_pkg::FULL_BYTES : nb_in;
			msg_bytes += nb;
			if (nb == sha_pkg::FULL_BYTES) begin
				load_word(data);
				load_word(sha_pkg::PAD_WORD);
			end else begin
				keep = (nb == 0) ? '0 : ~32'h0 << (32 - 8 * nb);
				load_word((data & keep) | (32'h80 << (24 - 8 * nb)));
			end
			if (fill > 14)
				while (fill != 0) load_word('0);
			while (fill < 14) load_word('0);
			bit_len = {msg_bytes, 3'b000};
			load_word(bit_len[63:32]);
			load_word(bit_len[31:0]);
			for (int i = 0; i < 8; i++) begin
				b.digest_word = chain[i];
				b.word_index  = i[2:0];
				b.last_word   = (i == 7);
				digest_q.push_back(b);
			end
			start_message();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_beat_t exp_b;
		if (!arst_n) begin
			start_message();
			digest_q.delete();
			fail_count <= 0;
			digests_seen <= 0;
			pending <= 0;
		end else begin
			if (in_mon.valid && in_mon.ready)
				absorb_request(in_mon.data_word, in_mon.valid_bytes, in_mon.last_item);
			if (out_mon.valid && out_mon.ready) begin
				if (digest_q.size() == 0) begin
					$display("%0t: unexpected digest word %h idx %0d", $time,
						out_mon.digest_word, out_mon.word_index);
					fail_count <= fail_count + 1;
				end else begin
					exp_b = digest_q.pop_front();
					if (exp_b.digest_word !== out_mon.digest_word
						|| exp_b.word_index !== out_mon.word_index
						|| exp_b.last_word !== out_mon.last_word) begin
						$display("%0t: digest mismatch exp %h/%0d/%0b got %h/%0d/%0b", $time,
							exp_b.digest_word, exp_b.word_index, exp_b.last_word,
							out_mon.digest_word, out_mon.word_index, out_mon.last_word);
						fail_count <= fail_count + 1;
					end
					if (out_mon.last_word) digests_seen <= digests_seen + 1;
				end
			end
			pending <= digest_q.size();
		end
	end
endmodule

FILE: bench/sha256_stream_hash_core_tb.sv
module sha256_stream_hash_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count, pending, digests_seen;
	int   req_count = 0;
	int   idle_cycles = 0;

	localparam int IDLE_LIMIT = 20000;

	sha_in_if  in_ch ();
	sha_out_if out_ch ();

	sha256_stream_hash_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	sha256_digest_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_mon       (in_ch),
		.out_mon      (out_ch),
		.fail_count   (fail_count),
		.pending      (pending),
		.digests_seen (digests_seen)
	);

	always #1 clk = ~clk;

	// gap length: mostly nothing or short, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	initial begin
		in_ch.valid       = 1'b0;
		in_ch.data_word   = '0;
		in_ch.valid_bytes = '0;
		in_ch.last_item   = 1'b0;
		out_ch.ready      = 1'b0;
	end

	// sink side: random back-pressure, with ready high more often than low
	always @(posedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 3) == 0)
				out_ch.ready <= 1'b1;
			else
				out_ch.ready <= ($urandom_range(0, 9) < 6);
		end
	end

	// one request: hold until accepted; valid stays high between back-to-back requests
	task automatic send_request(logic [31:0] d, logic [2:0] nb, logic lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.data_word   <= d;
		in_ch.valid_bytes <= nb;
		in_ch.last_item   <= lst;
		do @(posedge clk); while (!in_ch.ready);
		req_count++;
	endtask

	// message of n_full whole words, then a closing word with tail_nb bytes
	task automatic send_message(int n_full, logic [2:0] tail_nb, logic [31:0] fill_pat,
			logic rand_fill);
		for (int i = 0; i < n_full; i++)
			send_request(rand_fill ? $urandom() : fill_pat, 3'($urandom_range(0, 7)), 1'b0);
		send_request(rand_fill ? $urandom() : fill_pat, tail_nb, 1'b1);
	endtask

	// watchdog: cycles with no request accepted in either direction
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", idle_cycles);
			$display("sha256_stream_hash_core regression: fail");
			$finish;
		end
	end

	initial begin
		int n_full;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, every tail size incl. saturating 5..7,
		// pad crossing into the next word, length boundary at 55/56 bytes
		send_request(32'hffff_ffff, 3'd0, 1'b1);
		send_request(32'h6162_6300, 3'd3, 1'b1);
		send_request(32'hffff_ffff, 3'd4, 1'b1);
		send_request(32'h0000_0000, 3'd7, 1'b1);
		send_request(32'hdead_beef, 3'd5, 1'b1);
		send_request(32'ha5a5_a5a5, 3'd6, 1'b1);
		send_request(32'h1234_5678, 3'd1, 1'b1);
		send_request(32'h5a5a_5a5a, 3'd2, 1'b1);
		send_message(13, 3'd3, 32'hffff_ffff, 1'b0);
		send_message(13, 3'd4, 32'h0000_0000, 1'b0);

		// random: mostly short messages, a few spanning several blocks
		while (req_count < 360) begin
			if ($urandom_range(0, 9) == 0)
				n_full = $urandom_range(14, 40);
			else
				n_full = $urandom_range(0, 16);
			send_message(n_full, 3'($urandom_range(0, 7)), '0, 1'b1);
		end
		in_ch.valid <= 1'b0;
		// let the checker register the closing request before polling
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("sent %0d word requests; %0d digests checked, empty to multi-block messages",
			req_count, digests_seen);
		if (fail_count == 0)
			$display("sha256_stream_hash_core regression: pass");
		else
			$display("sha256_stream_hash_core regression: fail");
		$finish;
	end
endmodule
